// File: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/stfp_pkg.sv
// Shared types, codes and constants of the string table file parser.
// No dependencies.
`default_nettype none

package stfp_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ENTRY_BYTES_DEF   = 32;
  localparam int BUFFER_BYTES_DEF  = 1024;

  localparam logic [7:0] VERSION_RESET = 8'd1;
  localparam int         HEADER_BYTES  = 8;
  localparam int         MAX_WORDS     = 3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_CHARS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_TERM,
    KIND_STATUS
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_VERSION,
    ST_TRUNC
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  entry_index;
    logic [4:0]  char_pos;
    logic [7:0]  char_value;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic [1:0]              count;
    result_t [MAX_WORDS-1:0] slot;
  } bundle_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h41;
      2'd1:    val = 8'h32;
      2'd2:    val = 8'h4C;
      default: val = 8'h47;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: src/stfp_core.sv
// Parser state and per-byte step logic: header checks, key and string counters.
// Produces the words caused by one byte as a bundle. Depends on stfp_pkg.
`default_nettype none

module stfp_core
  import stfp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ENTRY_BYTES   = ENTRY_BYTES_DEF,
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_of_file,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output bundle_t         bundle
);

  localparam int OW = $clog2(BUFFER_BYTES + 1);
  localparam int KW = $clog2(ENTRY_BYTES);

  phase_t          phase_r, phase_nxt;
  logic [OW-1:0]   off_r, off_nxt;
  logic [7:0]      keys_total_r, keys_total_nxt;
  logic [7:0]      key_r, key_nxt;
  logic [7:0]      bytes_left_r, bytes_left_nxt;
  logic [7:0]      char_count_r, char_count_nxt;
  logic [KW-1:0]   kept_r, kept_nxt;
  logic            magic_ok_r, magic_ok_nxt;
  logic            version_ok_r, version_ok_nxt;
  logic [7:0]      version_r;

  logic            char_en, term_en, stat_en;
  logic [7:0]      term_key;
  logic [7:0]      term_pos;
  status_t         stat_val;

  always_comb begin
    logic fin;
    phase_nxt      = phase_r;
    off_nxt        = off_r;
    keys_total_nxt = keys_total_r;
    key_nxt        = key_r;
    bytes_left_nxt = bytes_left_r;
    char_count_nxt = char_count_r;
    kept_nxt       = kept_r;
    magic_ok_nxt   = magic_ok_r;
    version_ok_nxt = version_ok_r;
    char_en        = 1'b0;
    term_en        = 1'b0;
    stat_en        = 1'b0;
    term_key       = key_r;
    term_pos       = '0;
    stat_val       = ST_OK;
    fin            = 1'b0;
    if (take) begin
      if (off_r < OW'(BUFFER_BYTES)) begin
        off_nxt = off_r + OW'(1);
        case (phase_r)
          PH_HEADER: begin
            if (off_r < OW'(4)) begin
              if (byte_value != magic_byte(off_r[1:0])) magic_ok_nxt = 1'b0;
            end else if (off_r == OW'(4)) begin
              if (byte_value != version_r) version_ok_nxt = 1'b0;
            end else if (off_r == OW'(HEADER_BYTES - 1)) begin
              keys_total_nxt = byte_value;
              key_nxt        = '0;
              if (!magic_ok_r || !version_ok_r || byte_value == 8'd0) phase_nxt = PH_DONE;
              else phase_nxt = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            bytes_left_nxt = byte_value;
            char_count_nxt = '0;
            kept_nxt = (byte_value < 8'(ENTRY_BYTES - 1)) ? KW'(byte_value)
                                                           : KW'(ENTRY_BYTES - 1);
            if (byte_value == 8'd0) fin = 1'b1;
            else phase_nxt = PH_CHARS;
          end
          PH_CHARS: begin
            char_en = ({1'b0, key_r} < 9'(TABLE_ENTRIES)) && (char_count_r < 8'(kept_r));
            char_count_nxt = char_count_r + 8'd1;
            bytes_left_nxt = bytes_left_r - 8'd1;
            if (bytes_left_r == 8'd1) fin = 1'b1;
          end
          default: ;
        endcase
      end
      if (end_of_file && phase_nxt == PH_CHARS) fin = 1'b1;
      if (fin) begin
        term_en   = {1'b0, key_nxt} < 9'(TABLE_ENTRIES);
        term_key  = key_nxt;
        term_pos  = 8'(kept_nxt);
        key_nxt   = key_nxt + 8'd1;
        phase_nxt = (key_nxt == keys_total_nxt) ? PH_DONE : PH_LENGTH;
      end
      if (end_of_file) begin
        stat_en = 1'b1;
        if (phase_nxt == PH_HEADER || !magic_ok_nxt) stat_val = ST_SHORT;
        else if (!version_ok_nxt) stat_val = ST_VERSION;
        else if (phase_nxt == PH_LENGTH) stat_val = ST_TRUNC;
        else stat_val = ST_OK;
        phase_nxt      = PH_HEADER;
        off_nxt        = '0;
        keys_total_nxt = '0;
        key_nxt        = '0;
        bytes_left_nxt = '0;
        char_count_nxt = '0;
        kept_nxt       = '0;
        magic_ok_nxt   = 1'b1;
        version_ok_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    result_t c_res, t_res, s_res;
    c_res.kind        = KIND_CHAR;
    c_res.entry_index = key_r[5:0];
    c_res.char_pos    = char_count_r[4:0];
    c_res.char_value  = byte_value;
    c_res.status      = ST_OK;
    t_res.kind        = KIND_TERM;
    t_res.entry_index = term_key[5:0];
    t_res.char_pos    = term_pos[4:0];
    t_res.char_value  = '0;
    t_res.status      = ST_OK;
    s_res.kind        = KIND_STATUS;
    s_res.entry_index = '0;
    s_res.char_pos    = '0;
    s_res.char_value  = '0;
    s_res.status      = stat_val;
    bundle.count   = 2'(char_en) + 2'(term_en) + 2'(stat_en);
    bundle.slot[0] = char_en ? c_res : (term_en ? t_res : s_res);
    bundle.slot[1] = char_en ? (term_en ? t_res : s_res) : s_res;
    bundle.slot[2] = s_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      off_r        <= '0;
      keys_total_r <= '0;
      key_r        <= '0;
      bytes_left_r <= '0;
      char_count_r <= '0;
      kept_r       <= '0;
      magic_ok_r   <= 1'b1;
      version_ok_r <= 1'b1;
      version_r    <= VERSION_RESET;
    end else begin
      phase_r      <= phase_nxt;
      off_r        <= off_nxt;
      keys_total_r <= keys_total_nxt;
      key_r        <= key_nxt;
      bytes_left_r <= bytes_left_nxt;
      char_count_r <= char_count_nxt;
      kept_r       <= kept_nxt;
      magic_ok_r   <= magic_ok_nxt;
      version_ok_r <= version_ok_nxt;
      if (cfg_wr_en) version_r <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

// File: src/string_table_file_parser.sv
// String table file parser, top level: byte stream in, table writes and status out.
// Depends on stfp_pkg, stfp_core and assert_macros.svh.
//
// Takes a file one byte per word and emits character writes, entry terminators and one
// final status word per file, in order. A byte that causes at most one word is taken
// every cycle while out_tready is high; a byte that causes k words (k up to 3) holds
// the input until its last word is being sent, since the output register delivers one
// word per cycle while out_tready is high. The byte marked end_of_file carries the status
// and restarts the parser. The first word appears in the cycle after its byte is taken.
`default_nettype none

`include "assert_macros.svh"

module string_table_file_parser
  import stfp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ENTRY_BYTES   = ENTRY_BYTES_DEF,
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // byte_value
  input  wire logic        in_tlast,   // end_of_file
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // entry_index, char_pos, char_value, status, zero fill
  output      logic [1:0]  out_tuser,  // kind
  output      logic        out_tlast,  // last
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  bundle_t                 bundle;
  result_t [MAX_WORDS-1:0] slot_r, slot_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    in_fire, out_fire;

  stfp_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ENTRY_BYTES   (ENTRY_BYTES),
    .BUFFER_BYTES  (BUFFER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_fire),
    .byte_value  (in_tdata),
    .end_of_file (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bundle      (bundle)
  );

  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = cnt_r != 2'd0;
  assign out_fire   = out_tvalid && out_tready;

  assign out_tuser = slot_r[0].kind;
  assign out_tdata = {3'b000, slot_r[0].status, slot_r[0].char_value,
                      slot_r[0].char_pos, slot_r[0].entry_index};
  assign out_tlast = cnt_r == 2'd1;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      slot_nxt = bundle.slot;
      cnt_nxt  = bundle.count;
    end else if (out_fire) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> cnt_r == 2'd0, "words pending after reset")
  `ASSERT_CLK(a_status_is_last, out_tvalid && out_tuser == KIND_STATUS |-> out_tlast, "status word not last")
  `ASSERT_CLK(a_term_then_status, out_fire && out_tuser == KIND_TERM && !out_tlast |=> out_tvalid && out_tuser == KIND_STATUS, "terminator not followed by status")

endmodule

`default_nettype wire
